[hw/rtl/mbps_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// -----------------------------------------------------------------------------
package mbps_pkg;

   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 64;
   localparam int COUNT_W     = 16;
   localparam int LEN_REG_W   = 6;
   localparam int CMP_W       = 7;
   localparam int MASK_W      = 32;
   localparam int PAT_BYTES   = 32;
   localparam int PAT_IDX_W   = 5;
   localparam int PAT_WORDS   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [COUNT_W-1:0]   COUNT_MAX   = 16'hFFFF;
   localparam logic [LEN_REG_W-1:0] LEN_RESET   = 6'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LOW      = 3'd0,
      CSR_PAT_MID_LOW  = 3'd1,
      CSR_PAT_MID_HIGH = 3'd2,
      CSR_PAT_HIGH     = 3'd3,
      CSR_EXACT_MASK   = 3'd4,
      CSR_PAT_LENGTH   = 3'd5,
      CSR_RESULT_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              segment_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  match_address;
      logic [COUNT_W-1:0] match_number;
   } rsp_type;

   // Pattern byte lined up with one window cell.
   typedef struct packed {
      logic [BYTE_W-1:0] pat_byte;
      logic              exact;
      logic              in_use;
   } mbps_tap_type;

endpackage

[hw/rtl/mbps_align.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mbps_align
// Lines the configured pattern up with the window cells: cell j (j bytes back
// from the newest) meets pattern byte length-1-j. Registered every cycle.
// -----------------------------------------------------------------------------
module mbps_align #(
   parameter int MAX_LEN = 32
) (
   input  wire logic                                             clock,
   input  wire logic [mbps_pkg::PAT_BYTES*mbps_pkg::BYTE_W-1:0]  pattern_i,
   input  wire logic [mbps_pkg::MASK_W-1:0]                      exact_mask_i,
   input  wire logic [mbps_pkg::LEN_REG_W-1:0]                   length_i,
   output      mbps_pkg::mbps_tap_type [MAX_LEN-1:0]             taps_o,
   output      logic                                             any_exact_o,
   output      logic [mbps_pkg::CMP_W-1:0]                       len_m1_o
);

   localparam logic [mbps_pkg::CMP_W-1:0] MAX_C = mbps_pkg::CMP_W'(MAX_LEN);

   mbps_pkg::mbps_tap_type [MAX_LEN-1:0] taps_ff, taps_in;
   logic                                  any_exact_ff, any_exact_in;
   logic [mbps_pkg::CMP_W-1:0]            len_m1_ff, len_m1_in;
   logic [mbps_pkg::CMP_W-1:0]            len_wide;
   logic [mbps_pkg::CMP_W-1:0]            len_eff;
   logic [mbps_pkg::CMP_W-1:0]            idx [MAX_LEN];

   always_comb begin
      len_wide    = {1'b0, length_i};
      len_eff     = (len_wide > MAX_C) ? MAX_C : len_wide;
      len_m1_in   = len_eff - 1'b1;
      any_exact_in = 1'b0;
      for (int j = 0; j < MAX_LEN; j++) begin
         idx[j]            = len_eff - 1'b1 - mbps_pkg::CMP_W'(j);
         taps_in[j].in_use = (mbps_pkg::CMP_W'(j) < len_eff);
         taps_in[j].exact  = 1'b0;
         taps_in[j].pat_byte = '0;
         // pattern bytes past the register file act as wildcards
         if (taps_in[j].in_use && (idx[j] < mbps_pkg::CMP_W'(mbps_pkg::PAT_BYTES))) begin
            taps_in[j].exact    = exact_mask_i[idx[j][mbps_pkg::PAT_IDX_W-1:0]];
            taps_in[j].pat_byte =
               pattern_i[idx[j][mbps_pkg::PAT_IDX_W-1:0]*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
         end
         any_exact_in = any_exact_in | taps_in[j].exact;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff      <= taps_in;
      any_exact_ff <= any_exact_in;
      len_m1_ff    <= len_m1_in;
   end

   assign taps_o      = taps_ff;
   assign any_exact_o = any_exact_ff;
   assign len_m1_o    = len_m1_ff;

endmodule
`default_nettype wire

[hw/rtl/mbps_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mbps_cell
// One window cell: holds a byte and its segment valid bit, hands them to the
// next cell on each shift, and checks its byte against its pattern tap.
// -----------------------------------------------------------------------------
module mbps_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            shift_en,
   input  wire logic [mbps_pkg::BYTE_W-1:0]     byte_i,
   input  wire logic                            valid_i,
   input  wire mbps_pkg::mbps_tap_type          tap_i,
   output      logic [mbps_pkg::BYTE_W-1:0]     byte_o,
   output      logic                            valid_o,
   output      logic                            ok_o
);

   logic [mbps_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        valid_ff, valid_in;

   always_comb begin
      byte_in  = shift_en ? byte_i  : byte_ff;
      valid_in = shift_en ? valid_i : valid_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign byte_o  = byte_ff;
   assign valid_o = valid_ff;
   assign ok_o    = !tap_i.in_use ||
                    (valid_ff && (!tap_i.exact || (byte_ff == tap_i.pat_byte)));

endmodule
`default_nettype wire

[hw/rtl/masked_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Scans a byte stream for a masked pattern of up to MAX_PATTERN_LENGTH (32 by default) bytes.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one memory byte per item with its address and a flag that
//   opens a new contiguous segment. rsp_* carries one item per match: the
//   address of the match's first byte and the running match number.
//   csr_* writes the pattern words, exact mask, length and result limit;
//   write only while no item is in flight.
// Timing:
//   A byte enters the cell chain at acceptance; the next cycle every cell
//   compares against its pattern tap and a match loads the output register
//   once it is free; rsp_valid is driven from that register. One byte per
//   cycle is taken while no match waits on the output register. A byte that
//   matches waits in the chain only while the output register holds an item
//   the receiver has not taken; bytes that do not match retire even then.
// Reset:
//   Clears the window valid bits, match count and stop flag, and puts the
//   registers at their reset values (length 1, all else zero).
// -----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN_LENGTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire mbps_pkg::req_type                   req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      mbps_pkg::rsp_type                   rsp_payload,
   input  wire logic                                csr_write_en,
   input  wire logic [mbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mbps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CELLS = MAX_PATTERN_LENGTH;

   // configuration registers
   logic [mbps_pkg::ADDR_W-1:0]    pattern_ff [mbps_pkg::PAT_WORDS];
   logic [mbps_pkg::ADDR_W-1:0]    pattern_in [mbps_pkg::PAT_WORDS];
   logic [mbps_pkg::MASK_W-1:0]    exact_mask_ff, exact_mask_in;
   logic [mbps_pkg::LEN_REG_W-1:0] length_ff, length_in;
   logic [mbps_pkg::COUNT_W-1:0]   limit_ff, limit_in;
   logic [mbps_pkg::PAT_BYTES*mbps_pkg::BYTE_W-1:0] pattern_flat;

   // aligned taps
   mbps_pkg::mbps_tap_type [CELLS-1:0] taps;
   logic                               any_exact;
   logic [mbps_pkg::CMP_W-1:0]         len_m1;

   // cell chain
   logic [mbps_pkg::BYTE_W-1:0] cell_byte  [CELLS];
   logic [mbps_pkg::BYTE_W-1:0] chain_byte [CELLS];
   logic [CELLS-1:0]            chain_valid;
   logic [CELLS-1:0]            cell_valid;
   logic [CELLS-1:0]            cell_ok;

   // compare stage and match bookkeeping
   logic                          req_fire;
   logic                          s1_valid_ff, s1_valid_in;
   logic [mbps_pkg::ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic                          s1_hit;
   logic                          s1_retire;
   logic                          limit_eff;
   logic [mbps_pkg::COUNT_W-1:0]  found_ff, found_in;
   logic [mbps_pkg::COUNT_W-1:0]  found_next;
   logic                          limit_reached_ff, limit_reached_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mbps_pkg::rsp_type             rsp_payload_ff, rsp_payload_in;

   // ---------------------------------------------------------------- config
   always_comb begin
      for (int w = 0; w < mbps_pkg::PAT_WORDS; w++) begin
         pattern_in[w] = pattern_ff[w];
      end
      exact_mask_in = exact_mask_ff;
      length_in     = length_ff;
      limit_in      = limit_ff;
      if (csr_write_en) begin
         unique case (mbps_pkg::csr_index_type'(csr_index))
            mbps_pkg::CSR_PAT_LOW:      pattern_in[0] = csr_wdata;
            mbps_pkg::CSR_PAT_MID_LOW:  pattern_in[1] = csr_wdata;
            mbps_pkg::CSR_PAT_MID_HIGH: pattern_in[2] = csr_wdata;
            mbps_pkg::CSR_PAT_HIGH:     pattern_in[3] = csr_wdata;
            mbps_pkg::CSR_EXACT_MASK:   exact_mask_in = csr_wdata[mbps_pkg::MASK_W-1:0];
            mbps_pkg::CSR_PAT_LENGTH:   length_in     = csr_wdata[mbps_pkg::LEN_REG_W-1:0];
            mbps_pkg::CSR_RESULT_LIMIT: limit_in      = csr_wdata[mbps_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < mbps_pkg::PAT_WORDS; w++) begin
            pattern_ff[w] <= '0;
         end
         exact_mask_ff <= '0;
         length_ff     <= mbps_pkg::LEN_RESET;
         limit_ff      <= '0;
      end else begin
         for (int w = 0; w < mbps_pkg::PAT_WORDS; w++) begin
            pattern_ff[w] <= pattern_in[w];
         end
         exact_mask_ff <= exact_mask_in;
         length_ff     <= length_in;
         limit_ff      <= limit_in;
      end
   end

   always_comb begin
      for (int w = 0; w < mbps_pkg::PAT_WORDS; w++) begin
         pattern_flat[w*mbps_pkg::ADDR_W +: mbps_pkg::ADDR_W] = pattern_ff[w];
      end
   end

   mbps_align #(
      .MAX_LEN (CELLS)
   ) u_align (
      .clock        (clock),
      .pattern_i    (pattern_flat),
      .exact_mask_i (exact_mask_ff),
      .length_i     (length_ff),
      .taps_o       (taps),
      .any_exact_o  (any_exact),
      .len_m1_o     (len_m1)
   );

   // ------------------------------------------------------------ cell chain
   assign req_fire = req_valid && req_ready;

   // newest byte enters cell 0; a segment start drops every older byte
   always_comb begin
      chain_byte[0]  = req_payload.data_byte;
      chain_valid[0] = 1'b1;
      for (int c = 1; c < CELLS; c++) begin
         chain_byte[c]  = cell_byte[c-1];
         chain_valid[c] = cell_valid[c-1] && !req_payload.segment_start;
      end
   end

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      mbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_fire),
         .byte_i   (chain_byte[c]),
         .valid_i  (chain_valid[c]),
         .tap_i    (taps[c]),
         .byte_o   (cell_byte[c]),
         .valid_o  (cell_valid[c]),
         .ok_o     (cell_ok[c])
      );
   end

   // ------------------------------------------------------- compare stage
   always_comb begin
      limit_eff  = limit_reached_ff || ((limit_ff != '0) && (found_ff >= limit_ff));
      s1_hit     = s1_valid_ff && !limit_eff && any_exact && (&cell_ok);
      s1_retire  = s1_valid_ff && (!s1_hit || !rsp_valid_ff || rsp_ready);
      req_ready  = !s1_valid_ff || s1_retire;
      s1_valid_in = req_fire || (s1_valid_ff && !s1_retire);
      s1_addr_in  = req_fire ? req_payload.byte_address : s1_addr_ff;

      found_next = (found_ff == mbps_pkg::COUNT_MAX) ? found_ff : found_ff + 1'b1;
      found_in         = found_ff;
      limit_reached_in = limit_reached_ff;
      if (s1_retire) begin
         limit_reached_in = limit_eff;
         if (s1_hit) begin
            found_in         = found_next;
            limit_reached_in = (limit_ff != '0) && (found_next >= limit_ff);
         end
      end

      rsp_payload_in = rsp_payload_ff;
      if (s1_retire && s1_hit) begin
         rsp_payload_in.match_address = s1_addr_ff - mbps_pkg::ADDR_W'(len_m1);
         rsp_payload_in.match_number  = found_next;
      end
      rsp_valid_in = (s1_retire && s1_hit) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      s1_addr_ff     <= s1_addr_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         found_ff         <= '0;
         limit_reached_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         found_ff         <= found_in;
         limit_reached_ff <= limit_reached_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // the stop flag never clears outside reset
   a_limit_sticky: assert property (@(posedge clock) disable iff (reset)
      limit_reached_ff |=> limit_reached_ff)
      else $error("stop flag cleared");

   // window valid bits always form a run from the newest cell
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("window valid bits not contiguous");

   // the match count moves only as a result loads into the output register
   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      !$stable(found_ff) |-> rsp_valid_ff)
      else $error("match count moved without a result");

   // a match that retires always lands in the output register
   a_hit_loads: assert property (@(posedge clock) disable iff (reset)
      (s1_retire && s1_hit) |=> rsp_valid_ff && (rsp_payload_ff.match_number == found_ff))
      else $error("retired match not presented");
`endif

endmodule
`default_nettype wire
